// File: rtl/sfxp_pkg.sv
// ----------------------------------------------------------------------------
// sfxp_pkg: shared constants for the serial frame XOR parser
// Byte framing constants and the result packing layout on the master side.
// ----------------------------------------------------------------------------
package sfxp_pkg;

    localparam int BYTE_W    = 8;
    localparam int TYPE_W    = 3;
    localparam int SUBSYS_W  = 5;
    localparam int M_TDATA_W = 40;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'hFE;
    localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'hE0;
    localparam logic [BYTE_W-1:0] SUBSYS_MASK = 8'h1F;

    // master tdata field offsets, lowest bit up
    localparam int OFS_CMD_TYPE    = 0;
    localparam int OFS_SUBSYSTEM   = 3;
    localparam int OFS_COMMAND_ID  = 8;
    localparam int OFS_PAYLOAD_LEN = 16;
    localparam int OFS_PAYLOAD_IDX = 24;
    localparam int OFS_PAYLOAD_BYT = 32;

endpackage

// File: rtl/serial_frame_xor_parser.sv
// ----------------------------------------------------------------------------
// serial_frame_xor_parser: byte stream to frame fields with XOR check
// Results are registered: an accepted payload or check byte shows its result on the master side in the next cycle.
// Throughput: one byte per cycle; the output register frees the slave side
// whenever the held result is taken in the same cycle.
// Reset: synchronous, active low; parser returns to idle, no result is held.
// Each payload byte gives one result; the check byte gives a tlast result
// with tuser set when the received check equals the running XOR.
// ----------------------------------------------------------------------------
module serial_frame_xor_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfxp_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] cmd_type, [7:3] subsystem, [15:8] command_id,
    // [23:16] payload_length, [31:24] payload_index, [39:32] payload_byte
    output logic [sfxp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,   // result_kind
    output logic                            m_axis_tuser    // [0] checksum_ok
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_CMD0 = 3'd2;
    localparam logic [2:0] PH_CMD1 = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [2:0]                     r_phase, n_phase;
    logic [sfxp_pkg::BYTE_W-1:0]    r_len, n_len;
    logic [sfxp_pkg::BYTE_W-1:0]    r_count, n_count;
    logic [sfxp_pkg::BYTE_W-1:0]    r_xor, n_xor;
    logic [sfxp_pkg::TYPE_W-1:0]    r_type, n_type;
    logic [sfxp_pkg::SUBSYS_W-1:0]  r_subsys, n_subsys;
    logic [sfxp_pkg::BYTE_W-1:0]    r_cmd_id, n_cmd_id;

    logic                           r_out_valid;
    logic [sfxp_pkg::M_TDATA_W-1:0] r_out_data, n_out_data;
    logic                           r_out_last, n_out_last;
    logic                           r_out_ok, n_out_ok;
    logic                           n_emit;
    logic                           w_accept;
    logic [sfxp_pkg::BYTE_W-1:0]    w_b;
    logic [sfxp_pkg::BYTE_W-1:0]    w_idx, w_val;

    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_b           = s_axis_tdata;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_count    = r_count;
        n_xor      = r_xor;
        n_type     = r_type;
        n_subsys   = r_subsys;
        n_cmd_id   = r_cmd_id;
        n_emit     = 1'b0;
        n_out_last = 1'b0;
        n_out_ok   = 1'b0;
        w_idx      = '0;
        w_val      = '0;
        unique case (r_phase)
            PH_LEN: begin
                n_len   = w_b;
                n_count = '0;
                n_xor   = r_xor ^ w_b;
                n_phase = PH_CMD0;
            end
            PH_CMD0: begin
                n_type   = sfxp_pkg::TYPE_W'((w_b & sfxp_pkg::TYPE_MASK) >> 5);
                n_subsys = sfxp_pkg::SUBSYS_W'(w_b & sfxp_pkg::SUBSYS_MASK);
                n_xor    = r_xor ^ w_b;
                n_phase  = PH_CMD1;
            end
            PH_CMD1: begin
                n_cmd_id = w_b;
                n_xor    = r_xor ^ w_b;
                n_phase  = PH_BODY;
            end
            PH_BODY: begin
                n_emit = 1'b1;
                if (r_count < r_len) begin
                    w_idx   = r_count;
                    w_val   = w_b;
                    n_count = r_count + 1'b1;
                    n_xor   = r_xor ^ w_b;
                end else begin
                    n_out_last = 1'b1;
                    n_out_ok   = (r_xor == w_b);
                    n_phase    = PH_IDLE;
                end
            end
            default: begin
                if (w_b == sfxp_pkg::START_BYTE) begin
                    n_xor   = '0;
                    n_count = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
        n_out_data = {w_val, w_idx, r_len, r_cmd_id, r_subsys, r_type};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= '0;
            r_count     <= '0;
            r_xor       <= '0;
            r_type      <= '0;
            r_subsys    <= '0;
            r_cmd_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_count  <= n_count;
                r_xor    <= n_xor;
                r_type   <= n_type;
                r_subsys <= n_subsys;
                r_cmd_id <= n_cmd_id;
            end
            if (w_accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
            r_out_ok   <= n_out_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ok;

endmodule

// File: rtl/sfxp_checker.sv
// ----------------------------------------------------------------------------
// sfxp_checker: port-level checks for the serial frame XOR parser
// Watches both stream sides and flags results that break the framing rules.
// ----------------------------------------------------------------------------
module sfxp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [sfxp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic                            m_axis_tuser
);

    logic [sfxp_pkg::BYTE_W-1:0] w_len, w_idx, w_byte;
    logic                        w_in_seen;

    assign w_len     = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_LEN +: sfxp_pkg::BYTE_W];
    assign w_idx     = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_IDX +: sfxp_pkg::BYTE_W];
    assign w_byte    = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_BYT +: sfxp_pkg::BYTE_W];
    assign w_in_seen = s_axis_tvalid && s_axis_tready;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(w_in_seen))
        else $error("result without an accepted request");

    a_frame_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (w_idx == '0) && (w_byte == '0))
        else $error("frame end carries payload fields");

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (w_idx < w_len) && !m_axis_tuser)
        else $error("payload result outside declared length");

endmodule

bind serial_frame_xor_parser sfxp_checker u_sfxp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/serial_frame_xor_parser_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_xor_parser_tb: self-checking bench for the frame parser
// Streams framed bytes (start, length, command, id, payload, XOR check) and
// noise into the slave side, tracks the parser state alongside the block and
// compares every master-side result field by field against the tracked one.
// Both sides idle in random bursts; a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module serial_frame_xor_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        WAIT_SOF,
        GET_LEN,
        GET_CMD,
        GET_ID,
        GET_BODY
    } t_rx_phase;

    typedef struct packed {
        logic                              last;
        logic [sfxp_pkg::TYPE_W-1:0]       cmd_type;
        logic [sfxp_pkg::SUBSYS_W-1:0]     subsystem;
        logic [7:0]                        command_id;
        logic [7:0]                        payload_len;
        logic [7:0]                        payload_idx;
        logic [7:0]                        payload_val;
        logic                              ok;
    } t_frame_result;

    typedef logic [7:0] t_byte_q[$];

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [sfxp_pkg::BYTE_W-1:0]       s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [sfxp_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              m_axis_tuser;

    // parser tracking state
    t_rx_phase                         trk_phase = WAIT_SOF;
    logic [7:0]                        trk_len = '0;
    logic [7:0]                        trk_count = '0;
    logic [7:0]                        trk_xor = '0;
    logic [sfxp_pkg::TYPE_W-1:0]       trk_type = '0;
    logic [sfxp_pkg::SUBSYS_W-1:0]     trk_subsys = '0;
    logic [7:0]                        trk_id = '0;

    t_frame_result         frame_results_q[$];
    t_frame_result         got_res;
    t_frame_result         want_res;

    int                    error_cnt = 0;
    int                    bytes_parsed = 0;
    int                    bytes_ignored = 0;
    int                    payload_seen = 0;
    int                    frames_good = 0;
    int                    frames_bad = 0;
    int                    max_index_seen = 0;

    bit                    tx_gaps = 1'b1;
    bit                    rx_gaps = 1'b1;
    int                    rx_hold_left = 0;
    int                    rx_stall_left = 0;

    serial_frame_xor_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic string fmt_result(input t_frame_result r);
        return $sformatf("last=%0d type=%0d subsys=%0d id=%02h len=%0d idx=%0d val=%02h ok=%0d",
                         r.last, r.cmd_type, r.subsystem, r.command_id, r.payload_len,
                         r.payload_idx, r.payload_val, r.ok);
    endfunction

    task automatic report_error(input string msg);
        error_cnt++;
        if (error_cnt <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    task automatic track_parser(input logic [7:0] b);
        t_frame_result r;
        r = '0;
        case (trk_phase)
            GET_LEN: begin
                trk_len   = b;
                trk_count = '0;
                trk_xor   = trk_xor ^ b;
                trk_phase = GET_CMD;
            end
            GET_CMD: begin
                trk_type   = sfxp_pkg::TYPE_W'((b & sfxp_pkg::TYPE_MASK) >> 5);
                trk_subsys = sfxp_pkg::SUBSYS_W'(b & sfxp_pkg::SUBSYS_MASK);
                trk_xor    = trk_xor ^ b;
                trk_phase  = GET_ID;
            end
            GET_ID: begin
                trk_id    = b;
                trk_xor   = trk_xor ^ b;
                trk_phase = GET_BODY;
            end
            GET_BODY: begin
                r.cmd_type    = trk_type;
                r.subsystem   = trk_subsys;
                r.command_id  = trk_id;
                r.payload_len = trk_len;
                if (trk_count < trk_len) begin
                    r.last        = 1'b0;
                    r.payload_idx = trk_count;
                    r.payload_val = b;
                    r.ok          = 1'b0;
                    trk_count     = trk_count + 8'd1;
                    trk_xor       = trk_xor ^ b;
                end else begin
                    r.last        = 1'b1;
                    r.payload_idx = '0;
                    r.payload_val = '0;
                    r.ok          = (trk_xor == b);
                    trk_phase     = WAIT_SOF;
                end
                frame_results_q.push_back(r);
            end
            default: begin
                if (b == sfxp_pkg::START_BYTE) begin
                    trk_xor   = '0;
                    trk_count = '0;
                    trk_phase = GET_LEN;
                end else begin
                    trk_phase = WAIT_SOF;
                    bytes_ignored++;
                end
            end
        endcase
        if (!(trk_phase == WAIT_SOF && r.last == 1'b0 && b != sfxp_pkg::START_BYTE)) begin
            bytes_parsed++;
        end
    endtask

    // called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_parser(b);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd0, input logic [7:0] cmd1,
                              input t_byte_q body, input bit corrupt);
        logic [7:0] fcs;
        fcs = 8'(body.size()) ^ cmd0 ^ cmd1;
        foreach (body[i]) fcs = fcs ^ body[i];
        if (corrupt) fcs = fcs ^ 8'($urandom_range(1, 255));
        send_byte(sfxp_pkg::START_BYTE);
        send_byte(8'(body.size()));
        send_byte(cmd0);
        send_byte(cmd1);
        foreach (body[i]) send_byte(body[i]);
        send_byte(fcs);
    endtask

    task automatic send_random_frame(input int len, input bit corrupt);
        t_byte_q body;
        for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        send_frame(8'($urandom), 8'($urandom), body, corrupt);
    endtask

    task automatic wait_results_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (frame_results_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 20000) report_error("results did not drain");
        @(negedge i_clk);
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hFD);
        send_byte(8'h01);
        wait_results_drained();
    endtask

    task automatic test_zero_length();
        t_byte_q none;
        send_frame(8'hFF, 8'h00, none, 1'b0);
        send_frame(8'h00, 8'hFF, none, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_start_byte_in_frame();
        t_byte_q body;
        body = '{8'hFE, 8'h00, 8'hFF};
        send_frame(sfxp_pkg::START_BYTE, sfxp_pkg::START_BYTE, body, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_back_pressure();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        rx_hold_left = 150;
        @(negedge i_clk);
        send_random_frame(40, 1'b0);
        send_random_frame(3, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_max_length();
        send_random_frame(255, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_frames();
        int pick;
        while (bytes_parsed < 850) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else if (pick == 1) begin
                send_random_frame($urandom_range(9, 40), $urandom_range(0, 3) == 0);
            end else begin
                send_random_frame($urandom_range(0, 8), pick <= 3);
            end
        end
        wait_results_drained();
    endtask

    task automatic test_streaming();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (bytes_parsed < 1150) begin
            send_random_frame($urandom_range(0, 12), $urandom_range(0, 4) == 0);
        end
        wait_results_drained();
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = $urandom_range(1, 6) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.last        = m_axis_tlast;
            got_res.cmd_type    = m_axis_tdata[sfxp_pkg::OFS_CMD_TYPE +: sfxp_pkg::TYPE_W];
            got_res.subsystem   = m_axis_tdata[sfxp_pkg::OFS_SUBSYSTEM +: sfxp_pkg::SUBSYS_W];
            got_res.command_id  = m_axis_tdata[sfxp_pkg::OFS_COMMAND_ID +: 8];
            got_res.payload_len = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_LEN +: 8];
            got_res.payload_idx = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_IDX +: 8];
            got_res.payload_val = m_axis_tdata[sfxp_pkg::OFS_PAYLOAD_BYT +: 8];
            got_res.ok          = m_axis_tuser;
            if (frame_results_q.size() == 0) begin
                report_error({"unexpected result: ", fmt_result(got_res)});
            end else begin
                want_res = frame_results_q.pop_front();
                if (got_res.last !== want_res.last
                        || got_res.cmd_type !== want_res.cmd_type
                        || got_res.subsystem !== want_res.subsystem
                        || got_res.command_id !== want_res.command_id
                        || got_res.payload_len !== want_res.payload_len
                        || got_res.payload_idx !== want_res.payload_idx
                        || got_res.payload_val !== want_res.payload_val
                        || got_res.ok !== want_res.ok) begin
                    report_error({"mismatch\n  expected ", fmt_result(want_res),
                                  "\n  actual   ", fmt_result(got_res)});
                end
                if (want_res.last) begin
                    if (want_res.ok) frames_good++;
                    else frames_bad++;
                end else begin
                    payload_seen++;
                    if (want_res.payload_idx > max_index_seen) begin
                        max_index_seen = want_res.payload_idx;
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_bytes();
        test_zero_length();
        test_start_byte_in_frame();
        test_back_pressure();
        test_max_length();
        test_random_frames();
        test_streaming();

        repeat (4) @(posedge i_clk);
        if (frame_results_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", frame_results_q.size()));
        end

        $display("covered %0d parsed bytes and %0d idle bytes: %0d payload results",
                 bytes_parsed, bytes_ignored, payload_seen);
        $display("frame ends with good check %0d, bad check %0d, highest index %0d, errors %0d",
                 frames_good, frames_bad, max_index_seen, error_cnt);
        if (error_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
